/* design/guillotine_rect_packer_core_macros.svh */
// ----------------------------------------------------------------------------
// guillotine rect packer assertion macros
// shared concurrent assertion forms used at the top level
// ----------------------------------------------------------------------------
`ifndef GUILLOTINE_RECT_PACKER_CORE_MACROS_SVH
`define GUILLOTINE_RECT_PACKER_CORE_MACROS_SVH

// same-cycle implication
`define GRP_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define GRP_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/grp_pkg.sv */
// ----------------------------------------------------------------------------
// grp_pkg
// types and codes shared by the guillotine rect packer modules
// ----------------------------------------------------------------------------
package grp_pkg;

   localparam int COORD_W = 16;

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_FULL = 2'd1;
   localparam logic [1:0] STATUS_OVF  = 2'd2;

   localparam logic OP_PLACE = 1'b0;
   localparam logic OP_CLEAR = 1'b1;

   typedef struct packed {
      logic        op;
      logic [12:0] image_width;
      logic [12:0] image_height;
   } req_type;

   typedef struct packed {
      logic [15:0] place_x;
      logic [15:0] place_y;
      logic [15:0] atlas_width;
      logic [15:0] atlas_height;
      logic [1:0]  status;
   } rsp_type;

   typedef struct packed {
      logic       load;
      logic       clear;
      logic       scan;
      logic       grow;
      logic       remove;
      logic       shift_rd;
      logic       shift_wr;
      logic       dec;
      logic       app_r;
      logic       app_b;
      logic       finish;
      logic [1:0] fin_st;
   } cmd_type;

   typedef struct packed {
      logic scan_done;
      logic found;
      logic grow_ovf;
      logic grow_full;
      logic fit_full;
      logic shift_done;
      logic need_r;
      logic need_b;
      logic out_busy;
   } sts_type;

endpackage

/* design/grp_chan_if.sv */
// ----------------------------------------------------------------------------
// grp_chan_if
// valid/ready channel carrying one payload per transaction
// ----------------------------------------------------------------------------
interface grp_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

/* design/grp_ram.sv */
// ----------------------------------------------------------------------------
// grp_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module grp_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

/* design/grp_ctrl.sv */
// ----------------------------------------------------------------------------
// grp_ctrl
// sequencer for scan, split, shift and append of the free list
// ----------------------------------------------------------------------------
module grp_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_op,
   output logic             req_ready,
   input  grp_pkg::sts_type sts,
   output grp_pkg::cmd_type cmd
);
   typedef enum logic [8:0] {
      S_IDLE     = 9'b000000001,
      S_SCAN     = 9'b000000010,
      S_DECIDE   = 9'b000000100,
      S_SHIFT_RD = 9'b000001000,
      S_SHIFT_WR = 9'b000010000,
      S_APP_R    = 9'b000100000,
      S_APP_B    = 9'b001000000,
      S_FINISH   = 9'b010000000,
      S_SPARE    = 9'b100000000
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] st_ff, st_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      st_in    = st_ff;
      cmd      = '0;
      cmd.fin_st = st_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_op == grp_pkg::OP_CLEAR) begin
                  cmd.clear = 1'b1;
                  st_in     = grp_pkg::STATUS_OK;
                  state_in  = S_FINISH;
               end else begin
                  cmd.load = 1'b1;
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_done) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            state_in = S_FINISH;
            if (sts.found) begin
               if (sts.fit_full) begin
                  st_in = grp_pkg::STATUS_FULL;
               end else begin
                  cmd.remove = 1'b1;
                  st_in      = grp_pkg::STATUS_OK;
                  state_in   = S_SHIFT_RD;
               end
            end else if (sts.grow_ovf) begin
               st_in = grp_pkg::STATUS_OVF;
            end else if (sts.grow_full) begin
               st_in = grp_pkg::STATUS_FULL;
            end else begin
               cmd.grow = 1'b1;
               st_in    = grp_pkg::STATUS_OK;
            end
         end
         S_SHIFT_RD: begin
            if (sts.shift_done) begin
               cmd.dec = 1'b1;
               if (sts.need_r) begin
                  state_in = S_APP_R;
               end else if (sts.need_b) begin
                  state_in = S_APP_B;
               end else begin
                  state_in = S_FINISH;
               end
            end else begin
               cmd.shift_rd = 1'b1;
               state_in     = S_SHIFT_WR;
            end
         end
         S_SHIFT_WR: begin
            cmd.shift_wr = 1'b1;
            state_in     = S_SHIFT_RD;
         end
         S_APP_R: begin
            cmd.app_r = 1'b1;
            state_in  = sts.need_b ? S_APP_B : S_FINISH;
         end
         S_APP_B: begin
            cmd.app_b = 1'b1;
            state_in  = S_FINISH;
         end
         S_FINISH: begin
            if (!sts.out_busy) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         st_ff    <= grp_pkg::STATUS_OK;
      end else begin
         state_ff <= state_in;
         st_ff    <= st_in;
      end
   end
endmodule

/* design/grp_datapath.sv */
// ----------------------------------------------------------------------------
// grp_datapath
// free list store, best area fit search, texture size and result register
// ----------------------------------------------------------------------------
module grp_datapath #(
   parameter int FREE_SLOTS = 64,
   parameter int MAX_IMAGE  = 4096
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic [2:0]       csr_wdata,
   input  grp_pkg::req_type req_data,
   input  grp_pkg::cmd_type cmd,
   output grp_pkg::sts_type sts,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output grp_pkg::rsp_type rsp_data
);
   localparam int AW = (FREE_SLOTS > 1) ? $clog2(FREE_SLOTS) : 1;
   localparam int CW = $clog2(FREE_SLOTS + 1);
   localparam logic [15:0]   MAX_IMG_C = 16'(MAX_IMAGE);
   localparam logic [CW-1:0] SLOTS_C   = CW'(FREE_SLOTS);
   localparam logic [CW:0]   SLOTS_P1  = (CW + 1)'(FREE_SLOTS + 1);

   logic [2:0]    border_ff;
   logic [15:0]   iw_ff, ih_ff;
   logic [CW-1:0] scan_ptr_ff, count_ff, sh_ff;
   logic          dvld_ff, found_ff;
   logic [AW-1:0] data_idx_ff, best_idx_ff;
   logic [31:0]   best_area_ff;
   logic [15:0]   dx_ff, dy_ff, dw_ff, dh_ff;
   logic [15:0]   tex_w_ff, tex_h_ff;
   logic [15:0]   place_x_ff, place_y_ff;
   logic          rsp_valid_ff;
   grp_pkg::rsp_type rsp_data_ff;

   logic          issue;
   logic          wr_en, rd_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [63:0]   wr_data, rd_data;
   logic [15:0]   rx, ry, rw, rh;
   logic [31:0]   area;
   logic          fits;
   logic [15:0]   wsat, hsat, pad;
   logic [16:0]   grow_sum;
   logic          widen, side;
   logic [CW:0]   fit_total;
   logic [15:0]   bext;

   grp_ram #(.WIDTH(64), .DEPTH(FREE_SLOTS)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign bext  = {13'd0, border_ff};
   assign pad   = {12'd0, border_ff, 1'b0};
   assign wsat  = ({3'd0, req_data.image_width} > MAX_IMG_C) ? MAX_IMG_C
                : {3'd0, req_data.image_width};
   assign hsat  = ({3'd0, req_data.image_height} > MAX_IMG_C) ? MAX_IMG_C
                : {3'd0, req_data.image_height};

   assign issue   = cmd.scan && (scan_ptr_ff < count_ff);
   assign rd_en   = issue || cmd.shift_rd;
   assign rd_addr = cmd.shift_rd ? sh_ff[AW-1:0] : scan_ptr_ff[AW-1:0];

   assign rx   = rd_data[63:48];
   assign ry   = rd_data[47:32];
   assign rw   = rd_data[31:16];
   assign rh   = rd_data[15:0];
   assign area = rw * rh;
   assign fits = (rw >= iw_ff) && (rh >= ih_ff);

   assign grow_sum  = {1'b0, tex_h_ff} + {1'b0, ih_ff};
   assign widen     = tex_w_ff < iw_ff;
   assign side      = widen ? (tex_h_ff != 16'd0) : (iw_ff < tex_w_ff);
   assign fit_total = {1'b0, count_ff} + (CW + 1)'(sts.need_r) + (CW + 1)'(sts.need_b);

   always_comb begin
      sts            = '0;
      sts.scan_done  = !issue && !dvld_ff;
      sts.found      = found_ff;
      sts.grow_ovf   = grow_sum[16];
      sts.grow_full  = side && (count_ff >= SLOTS_C);
      sts.need_r     = dw_ff > iw_ff;
      sts.need_b     = dh_ff > ih_ff;
      sts.fit_full   = fit_total > SLOTS_P1;
      sts.shift_done = sh_ff >= count_ff;
      sts.out_busy   = rsp_valid_ff && !rsp_ready;
   end

   // one store port shared by growth, shift and split appends
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = count_ff[AW-1:0];
      wr_data = rd_data;
      if (cmd.grow && side) begin
         wr_en = 1'b1;
         if (widen) begin
            wr_data = {tex_w_ff, 16'd0, iw_ff - tex_w_ff, tex_h_ff};
         end else begin
            wr_data = {iw_ff, tex_h_ff, tex_w_ff - iw_ff, ih_ff};
         end
      end else if (cmd.shift_wr) begin
         wr_en   = 1'b1;
         wr_addr = AW'(sh_ff - CW'(1));
      end else if (cmd.app_r) begin
         wr_en   = 1'b1;
         wr_data = {dx_ff + iw_ff, dy_ff, dw_ff - iw_ff, ih_ff};
      end else if (cmd.app_b) begin
         wr_en   = 1'b1;
         wr_data = {dx_ff, dy_ff + ih_ff, dw_ff, dh_ff - ih_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         border_ff    <= 3'd1;
         count_ff     <= '0;
         tex_w_ff     <= '0;
         tex_h_ff     <= '0;
         dvld_ff      <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            border_ff <= csr_wdata;
         end
         dvld_ff <= issue;
         if (cmd.load) begin
            found_ff <= 1'b0;
         end else if (cmd.scan && dvld_ff && fits && (!found_ff || area < best_area_ff)) begin
            found_ff <= 1'b1;
         end
         if (cmd.clear) begin
            count_ff <= '0;
            tex_w_ff <= '0;
            tex_h_ff <= '0;
         end else if (cmd.grow) begin
            tex_h_ff <= grow_sum[15:0];
            if (widen) begin
               tex_w_ff <= iw_ff;
            end
            if (side) begin
               count_ff <= count_ff + CW'(1);
            end
         end else if (cmd.dec) begin
            count_ff <= count_ff - CW'(1);
         end else if (cmd.app_r || cmd.app_b) begin
            count_ff <= count_ff + CW'(1);
         end
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         iw_ff       <= wsat + pad;
         ih_ff       <= hsat + pad;
         scan_ptr_ff <= '0;
      end else if (issue) begin
         scan_ptr_ff <= scan_ptr_ff + CW'(1);
      end
      if (issue) begin
         data_idx_ff <= scan_ptr_ff[AW-1:0];
      end
      // strict less keeps the earliest entry on equal area
      if (cmd.scan && dvld_ff && fits && (!found_ff || area < best_area_ff)) begin
         best_area_ff <= area;
         best_idx_ff  <= data_idx_ff;
         dx_ff        <= rx;
         dy_ff        <= ry;
         dw_ff        <= rw;
         dh_ff        <= rh;
      end
      if (cmd.remove) begin
         sh_ff <= CW'(best_idx_ff) + CW'(1);
      end else if (cmd.shift_wr) begin
         sh_ff <= sh_ff + CW'(1);
      end
      if (cmd.clear) begin
         place_x_ff <= '0;
         place_y_ff <= '0;
      end else if (cmd.grow) begin
         place_x_ff <= bext;
         place_y_ff <= tex_h_ff + bext;
      end else if (cmd.remove) begin
         place_x_ff <= dx_ff + bext;
         place_y_ff <= dy_ff + bext;
      end
      if (cmd.finish) begin
         rsp_data_ff.place_x      <= (cmd.fin_st == grp_pkg::STATUS_OK) ? place_x_ff : 16'd0;
         rsp_data_ff.place_y      <= (cmd.fin_st == grp_pkg::STATUS_OK) ? place_y_ff : 16'd0;
         rsp_data_ff.atlas_width  <= tex_w_ff;
         rsp_data_ff.atlas_height <= tex_h_ff;
         rsp_data_ff.status       <= cmd.fin_st;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
endmodule

/* design/guillotine_rect_packer_core.sv */
// ----------------------------------------------------------------------------
// guillotine_rect_packer_core
// guillotine atlas packer with best area fit over a free rectangle list
// ----------------------------------------------------------------------------
//  channel  dir  transaction
//  req_ch   in   op, image_width, image_height
//  rsp_ch   out  place_x, place_y, atlas_width, atlas_height, status
//  csr_*    in   border_size write, no read-back
//
//  after the accept cycle a clear goes straight to finish; a place scans the
//  free entries through the store's registered read port, then decides and
//  finishes; a fit also reads and writes back each entry after the chosen one
//  to close the gap, then appends the right and bottom splits as needed
//  reset empties the free list and the texture and sets border_size to 1
//  the result register lets a new transaction in while a result waits
// ----------------------------------------------------------------------------
`include "guillotine_rect_packer_core_macros.svh"

module guillotine_rect_packer_core #(
   parameter int FREE_SLOTS = 64,
   parameter int MAX_IMAGE  = 4096
) (
   input  logic       clock,
   input  logic       reset,
   grp_chan_if.sink   req_ch,
   grp_chan_if.source rsp_ch,
   input  logic       csr_we,
   input  logic [2:0] csr_wdata
);
   grp_pkg::cmd_type cmd;
   grp_pkg::sts_type sts;
   grp_pkg::req_type req_data;
   grp_pkg::rsp_type rsp_data;

   assign req_data       = req_ch.payload;
   assign rsp_ch.payload = rsp_data;

   grp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_op    (req_data.op),
      .req_ready (req_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   grp_datapath #(.FREE_SLOTS(FREE_SLOTS), .MAX_IMAGE(MAX_IMAGE)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .rsp_data  (rsp_data)
   );

   `GRP_ASSERT_NXT(a_busy_after_accept, clock, reset, req_ch.valid && req_ch.ready, !req_ch.ready, "request accepted while still busy")
   `GRP_ASSERT_IMP(a_finish_when_free, clock, reset, cmd.finish, !(rsp_ch.valid && !rsp_ch.ready), "result register overwritten")
   `GRP_ASSERT_IMP(a_fail_no_place, clock, reset, rsp_ch.valid && rsp_data.status != grp_pkg::STATUS_OK, rsp_data.place_x == 16'd0 && rsp_data.place_y == 16'd0, "failed placement reports a position")
endmodule
